// File: rtl/core/rb2d_pkg.sv
package rb2d_pkg;

   localparam int unsigned DATA_W = 32;   // Q16.16 state and field width
   localparam int unsigned COEF_W = 31;   // unsigned coefficient registers
   localparam int unsigned FRAC_W = 16;
   localparam int unsigned OPND_W = DATA_W + 1;
   localparam int unsigned FULL_W = 2 * OPND_W;
   localparam int unsigned PROD_W = 48;   // floor(a*b/2^16) always fits here
   localparam int unsigned WIDE_W = 50;   // headroom for sums before saturation
   localparam int unsigned ADDR_W = 5;
   localparam int unsigned PC_W   = 4;

   localparam logic [PC_W-1:0] TICK_BASE  = 4'd0;
   localparam logic [PC_W-1:0] TICK_LAST  = 4'd10;
   localparam logic [PC_W-1:0] FORCE_BASE = 4'd11;

   localparam logic signed [DATA_W-1:0] LINEAR_REST_LIMIT  = 32'sd13107;
   localparam logic signed [DATA_W-1:0] ANGULAR_REST_LIMIT = 32'sd655;

   localparam logic [DATA_W-1:0] RST_TIME_STEP = 32'd1092;
   localparam logic [DATA_W-1:0] RST_DRAG      = 32'd19661;
   localparam logic [DATA_W-1:0] RST_INVERSE   = 32'd65536;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_FORCE = 2'd1,
      OP_SET   = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      REG_GRAVITY_X      = 3'd0,
      REG_GRAVITY_Y      = 3'd1,
      REG_TIME_STEP      = 3'd2,
      REG_LINEAR_DRAG    = 3'd3,
      REG_ANGULAR_DRAG   = 3'd4,
      REG_INVERSE_MASS   = 3'd5,
      REG_INVERSE_MOMENT = 3'd6,
      REG_KINEMATIC      = 3'd7
   } reg_type;

   typedef enum logic [2:0] {
      SRC_VX, SRC_VY, SRC_GX, SRC_GY, SRC_SPIN, SRC_TMP, SRC_FX, SRC_FY
   } srca_type;

   typedef enum logic [2:0] {
      COEF_STEP, COEF_LDRAG, COEF_ADRAG, COEF_IMASS, COEF_IMOM, COEF_SX, COEF_SY
   } srcb_type;

   typedef enum logic [2:0] {
      ACT_ADD, ACT_SUB, ACT_TMP, ACT_RAW, ACT_TORQUE
   } act_type;

   typedef enum logic [2:0] {
      DST_PX, DST_PY, DST_VX, DST_VY, DST_HEAD, DST_SPIN
   } dst_type;

   typedef struct packed {
      srca_type a;
      srcb_type b;
      act_type  act;
      dst_type  dst;
      logic     snap;
      logic     last;
   } uop_type;

   // Micro-program: tick occupies 0..10, force occupies 11..15.
   function automatic uop_type uop_rom(input logic [PC_W-1:0] pc);
      uop_type u;
      u = '{SRC_VX, COEF_STEP, ACT_ADD, DST_PX, 1'b0, 1'b0};
      case (pc)
         4'd0:  u = '{SRC_VX,   COEF_STEP,  ACT_ADD,    DST_PX,   1'b0, 1'b0};
         4'd1:  u = '{SRC_VY,   COEF_STEP,  ACT_ADD,    DST_PY,   1'b0, 1'b0};
         4'd2:  u = '{SRC_GX,   COEF_STEP,  ACT_ADD,    DST_VX,   1'b0, 1'b0};
         4'd3:  u = '{SRC_GY,   COEF_STEP,  ACT_ADD,    DST_VY,   1'b0, 1'b0};
         4'd4:  u = '{SRC_VX,   COEF_LDRAG, ACT_TMP,    DST_PX,   1'b0, 1'b0};
         4'd5:  u = '{SRC_TMP,  COEF_STEP,  ACT_SUB,    DST_VX,   1'b0, 1'b0};
         4'd6:  u = '{SRC_VY,   COEF_LDRAG, ACT_TMP,    DST_PX,   1'b0, 1'b0};
         4'd7:  u = '{SRC_TMP,  COEF_STEP,  ACT_SUB,    DST_VY,   1'b0, 1'b0};
         4'd8:  u = '{SRC_SPIN, COEF_ADRAG, ACT_TMP,    DST_PX,   1'b0, 1'b0};
         4'd9:  u = '{SRC_TMP,  COEF_STEP,  ACT_SUB,    DST_SPIN, 1'b0, 1'b0};
         4'd10: u = '{SRC_SPIN, COEF_STEP,  ACT_ADD,    DST_HEAD, 1'b1, 1'b1};
         4'd11: u = '{SRC_FY,   COEF_SX,    ACT_RAW,    DST_PX,   1'b0, 1'b0};
         4'd12: u = '{SRC_FX,   COEF_SY,    ACT_TORQUE, DST_PX,   1'b0, 1'b0};
         4'd13: u = '{SRC_FX,   COEF_IMASS, ACT_ADD,    DST_VX,   1'b0, 1'b0};
         4'd14: u = '{SRC_FY,   COEF_IMASS, ACT_ADD,    DST_VY,   1'b0, 1'b0};
         4'd15: u = '{SRC_TMP,  COEF_IMOM,  ACT_ADD,    DST_SPIN, 1'b0, 1'b1};
         default: u = '{SRC_VX, COEF_STEP,  ACT_ADD,    DST_PX,   1'b0, 1'b1};
      endcase
      return u;
   endfunction

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = {{(WIDE_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
      lo = {{(WIDE_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};
      if (v > hi) begin
         return {1'b0, {(DATA_W-1){1'b1}}};
      end else if (v < lo) begin
         return {1'b1, {(DATA_W-1){1'b0}}};
      end
      return v[DATA_W-1:0];
   endfunction

   function automatic logic signed [WIDE_W-1:0] widen(input logic signed [DATA_W-1:0] v);
      return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
   endfunction

endpackage

// File: rtl/core/rigid_body_2d_integrator.sv
// Channel   Direction  Transfer condition          Payload
// req       in         req_valid & req_ready       operation, first/second x/y, set_*
// rsp       out        rsp_valid & rsp_ready       position, velocity, heading, spin_rate
// csr       in/out     psel & penable & pwrite     8 registers at byte address 4*i
//
// Every multiply goes through one shared 33x33 multiplier; each step
// multiplies into a register, then saturates and accumulates. A tick runs 11
// steps and a force runs 5; set, kinematic tick and unused codes run no steps.
// No new item is taken until the last result is in the output register. Reset
// loads register defaults and zeroes the body state. A result waits in the
// output register while the next item is taken; the sequencer holds only if a
// new result finds it still full.
module rigid_body_2d_integrator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_operation,
   input  logic signed [rb2d_pkg::DATA_W-1:0]  req_first_x,
   input  logic signed [rb2d_pkg::DATA_W-1:0]  req_first_y,
   input  logic signed [rb2d_pkg::DATA_W-1:0]  req_second_x,
   input  logic signed [rb2d_pkg::DATA_W-1:0]  req_second_y,
   input  logic signed [rb2d_pkg::DATA_W-1:0]  req_set_heading,
   input  logic signed [rb2d_pkg::DATA_W-1:0]  req_set_spin,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rb2d_pkg::DATA_W-1:0]  rsp_position_x,
   output logic signed [rb2d_pkg::DATA_W-1:0]  rsp_position_y,
   output logic signed [rb2d_pkg::DATA_W-1:0]  rsp_velocity_x,
   output logic signed [rb2d_pkg::DATA_W-1:0]  rsp_velocity_y,
   output logic signed [rb2d_pkg::DATA_W-1:0]  rsp_heading,
   output logic signed [rb2d_pkg::DATA_W-1:0]  rsp_spin_rate,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rb2d_pkg::ADDR_W-1:0]         csr_paddr,
   input  logic [rb2d_pkg::DATA_W-1:0]         csr_pwdata,
   output logic [rb2d_pkg::DATA_W-1:0]         csr_prdata,
   output logic                                csr_pready
);
   import rb2d_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_MUL, S_ACC, S_DONE} state_type;

   state_type state_ff, state_in;
   logic [PC_W-1:0] pc_ff, pc_in;
   logic tick_ff, tick_in;
   logic rsp_valid_ff, rsp_valid_in;

   // configuration
   logic signed [DATA_W-1:0] grav_x_ff, grav_x_in, grav_y_ff, grav_y_in;
   logic [COEF_W-1:0] step_ff, step_in, ldrag_ff, ldrag_in, adrag_ff, adrag_in;
   logic [COEF_W-1:0] imass_ff, imass_in, imom_ff, imom_in;
   logic kin_ff, kin_in;

   // body state
   logic signed [DATA_W-1:0] pos_x_ff, pos_x_in, pos_y_ff, pos_y_in;
   logic signed [DATA_W-1:0] vel_x_ff, vel_x_in, vel_y_ff, vel_y_in;
   logic signed [DATA_W-1:0] head_ff, head_in, spin_ff, spin_in;

   // captured item operands and scratch
   logic signed [DATA_W-1:0] arg_fx_ff, arg_fx_in, arg_fy_ff, arg_fy_in;
   logic signed [DATA_W-1:0] arg_sx_ff, arg_sx_in, arg_sy_ff, arg_sy_in;
   logic signed [DATA_W-1:0] tmp_ff, tmp_in;
   logic signed [PROD_W-1:0] raw_ff, raw_in, prod_ff, prod_in;

   // result register
   logic signed [DATA_W-1:0] out_px_ff, out_px_in, out_py_ff, out_py_in;
   logic signed [DATA_W-1:0] out_vx_ff, out_vx_in, out_vy_ff, out_vy_in;
   logic signed [DATA_W-1:0] out_hd_ff, out_hd_in, out_sp_ff, out_sp_in;

   // shared datapath
   uop_type                  uop;
   logic signed [DATA_W-1:0] mul_a;
   logic signed [OPND_W-1:0] mul_b;
   logic signed [FULL_W-1:0] prod_full;
   logic signed [DATA_W-1:0] prod_sat;
   logic signed [DATA_W-1:0] dst_cur;
   logic signed [DATA_W-1:0] acc_res;
   logic signed [WIDE_W-1:0] prod_wide;
   logic signed [WIDE_W-1:0] raw_wide;
   logic [2:0]               reg_idx;
   logic                     csr_wr;

   assign uop       = uop_rom(pc_ff);
   assign reg_idx   = csr_paddr[ADDR_W-1:2];
   assign csr_wr    = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   // operand select for the shared multiplier
   always_comb begin
      case (uop.a)
         SRC_VX:   mul_a = vel_x_ff;
         SRC_VY:   mul_a = vel_y_ff;
         SRC_GX:   mul_a = grav_x_ff;
         SRC_GY:   mul_a = grav_y_ff;
         SRC_SPIN: mul_a = spin_ff;
         SRC_TMP:  mul_a = tmp_ff;
         SRC_FX:   mul_a = arg_fx_ff;
         SRC_FY:   mul_a = arg_fy_ff;
         default:  mul_a = '0;
      endcase
      case (uop.b)
         COEF_STEP:  mul_b = {2'b00, step_ff};
         COEF_LDRAG: mul_b = {2'b00, ldrag_ff};
         COEF_ADRAG: mul_b = {2'b00, adrag_ff};
         COEF_IMASS: mul_b = {2'b00, imass_ff};
         COEF_IMOM:  mul_b = {2'b00, imom_ff};
         COEF_SX:    mul_b = {arg_sx_ff[DATA_W-1], arg_sx_ff};
         COEF_SY:    mul_b = {arg_sy_ff[DATA_W-1], arg_sy_ff};
         default:    mul_b = '0;
      endcase
   end

   // arithmetic shift right by the fraction width is the floor of the Q16.16 product
   assign prod_full = $signed({mul_a[DATA_W-1], mul_a}) * mul_b;
   assign prod_wide = {{(WIDE_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign raw_wide  = {{(WIDE_W-PROD_W){raw_ff[PROD_W-1]}}, raw_ff};
   assign prod_sat  = sat32(prod_wide);

   always_comb begin
      case (uop.dst)
         DST_PX:   dst_cur = pos_x_ff;
         DST_PY:   dst_cur = pos_y_ff;
         DST_VX:   dst_cur = vel_x_ff;
         DST_VY:   dst_cur = vel_y_ff;
         DST_HEAD: dst_cur = head_ff;
         DST_SPIN: dst_cur = spin_ff;
         default:  dst_cur = '0;
      endcase
      if (uop.act == ACT_SUB) begin
         acc_res = sat32(widen(dst_cur) - widen(prod_sat));
      end else begin
         acc_res = sat32(widen(dst_cur) + widen(prod_sat));
      end
   end

   // register read
   always_comb begin
      case (reg_type'(reg_idx))
         REG_GRAVITY_X:      csr_prdata = grav_x_ff;
         REG_GRAVITY_Y:      csr_prdata = grav_y_ff;
         REG_TIME_STEP:      csr_prdata = {1'b0, step_ff};
         REG_LINEAR_DRAG:    csr_prdata = {1'b0, ldrag_ff};
         REG_ANGULAR_DRAG:   csr_prdata = {1'b0, adrag_ff};
         REG_INVERSE_MASS:   csr_prdata = {1'b0, imass_ff};
         REG_INVERSE_MOMENT: csr_prdata = {1'b0, imom_ff};
         REG_KINEMATIC:      csr_prdata = {{(DATA_W-1){1'b0}}, kin_ff};
         default:            csr_prdata = '0;
      endcase
   end

   // sequencer and next-state logic
   always_comb begin
      state_in     = state_ff;
      pc_in        = pc_ff;
      tick_in      = tick_ff;
      rsp_valid_in = rsp_valid_ff;
      grav_x_in = grav_x_ff;  grav_y_in = grav_y_ff;
      step_in   = step_ff;    ldrag_in  = ldrag_ff;   adrag_in = adrag_ff;
      imass_in  = imass_ff;   imom_in   = imom_ff;    kin_in   = kin_ff;
      pos_x_in  = pos_x_ff;   pos_y_in  = pos_y_ff;
      vel_x_in  = vel_x_ff;   vel_y_in  = vel_y_ff;
      head_in   = head_ff;    spin_in   = spin_ff;
      arg_fx_in = arg_fx_ff;  arg_fy_in = arg_fy_ff;
      arg_sx_in = arg_sx_ff;  arg_sy_in = arg_sy_ff;
      tmp_in    = tmp_ff;     raw_in    = raw_ff;     prod_in  = prod_ff;
      out_px_in = out_px_ff;  out_py_in = out_py_ff;
      out_vx_in = out_vx_ff;  out_vy_in = out_vy_ff;
      out_hd_in = out_hd_ff;  out_sp_in = out_sp_ff;

      // drop the result once the sink takes it
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_wr) begin
         case (reg_type'(reg_idx))
            REG_GRAVITY_X:      grav_x_in = csr_pwdata;
            REG_GRAVITY_Y:      grav_y_in = csr_pwdata;
            REG_TIME_STEP:      step_in   = csr_pwdata[COEF_W-1:0];
            REG_LINEAR_DRAG:    ldrag_in  = csr_pwdata[COEF_W-1:0];
            REG_ANGULAR_DRAG:   adrag_in  = csr_pwdata[COEF_W-1:0];
            REG_INVERSE_MASS:   imass_in  = csr_pwdata[COEF_W-1:0];
            REG_INVERSE_MOMENT: imom_in   = csr_pwdata[COEF_W-1:0];
            REG_KINEMATIC:      kin_in    = csr_pwdata[0];
            default:            kin_in    = kin_ff;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               arg_fx_in = req_first_x;
               arg_fy_in = req_first_y;
               arg_sx_in = req_second_x;
               arg_sy_in = req_second_y;
               tick_in   = (req_operation == OP_TICK);
               state_in  = S_DONE;
               case (op_type'(req_operation))
                  OP_TICK: begin
                     if (kin_ff) begin
                        // kinematic body: kill motion, keep pose
                        vel_x_in = '0;
                        vel_y_in = '0;
                        spin_in  = '0;
                     end else begin
                        pc_in    = TICK_BASE;
                        state_in = S_MUL;
                     end
                  end
                  OP_FORCE: begin
                     pc_in    = FORCE_BASE;
                     state_in = S_MUL;
                  end
                  OP_SET: begin
                     pos_x_in = req_first_x;
                     pos_y_in = req_first_y;
                     vel_x_in = req_second_x;
                     vel_y_in = req_second_y;
                     head_in  = req_set_heading;
                     spin_in  = req_set_spin;
                  end
                  default: begin
                     // unused code: report state as is
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_MUL: begin
            prod_in  = prod_full[PROD_W+FRAC_W-1:FRAC_W];
            state_in = S_ACC;
         end
         S_ACC: begin
            case (uop.act)
               ACT_TMP:    tmp_in = prod_sat;
               ACT_RAW:    raw_in = prod_ff;
               ACT_TORQUE: tmp_in = sat32(raw_wide - prod_wide);
               default: begin
                  case (uop.dst)
                     DST_PX:   pos_x_in = acc_res;
                     DST_PY:   pos_y_in = acc_res;
                     DST_VX:   vel_x_in = acc_res;
                     DST_VY:   vel_y_in = acc_res;
                     DST_HEAD: head_in  = acc_res;
                     DST_SPIN: spin_in  = acc_res;
                     default:  head_in  = head_ff;
                  endcase
               end
            endcase
            // rest snap: velocity x and spin are final by the heading step
            if (uop.snap) begin
               if (vel_x_ff < LINEAR_REST_LIMIT && vel_x_ff > -LINEAR_REST_LIMIT) begin
                  vel_x_in = '0;
               end
               if (spin_ff < ANGULAR_REST_LIMIT && spin_ff > -ANGULAR_REST_LIMIT) begin
                  spin_in = '0;
               end
            end
            if (uop.last) begin
               state_in = S_DONE;
            end else begin
               pc_in    = pc_ff + 1'b1;
               state_in = S_MUL;
            end
         end
         S_DONE: begin
            // hold until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               out_px_in    = pos_x_ff;
               out_py_in    = pos_y_ff;
               out_vx_in    = vel_x_ff;
               out_vy_in    = vel_y_ff;
               out_hd_in    = head_ff;
               out_sp_in    = spin_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         pc_ff        <= TICK_BASE;
         tick_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         grav_x_ff    <= '0;
         grav_y_ff    <= '0;
         step_ff      <= RST_TIME_STEP[COEF_W-1:0];
         ldrag_ff     <= RST_DRAG[COEF_W-1:0];
         adrag_ff     <= RST_DRAG[COEF_W-1:0];
         imass_ff     <= RST_INVERSE[COEF_W-1:0];
         imom_ff      <= RST_INVERSE[COEF_W-1:0];
         kin_ff       <= 1'b0;
         pos_x_ff     <= '0;
         pos_y_ff     <= '0;
         vel_x_ff     <= '0;
         vel_y_ff     <= '0;
         head_ff      <= '0;
         spin_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         pc_ff        <= pc_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
         grav_x_ff    <= grav_x_in;
         grav_y_ff    <= grav_y_in;
         step_ff      <= step_in;
         ldrag_ff     <= ldrag_in;
         adrag_ff     <= adrag_in;
         imass_ff     <= imass_in;
         imom_ff      <= imom_in;
         kin_ff       <= kin_in;
         pos_x_ff     <= pos_x_in;
         pos_y_ff     <= pos_y_in;
         vel_x_ff     <= vel_x_in;
         vel_y_ff     <= vel_y_in;
         head_ff      <= head_in;
         spin_ff      <= spin_in;
      end
      arg_fx_ff <= arg_fx_in;
      arg_fy_ff <= arg_fy_in;
      arg_sx_ff <= arg_sx_in;
      arg_sy_ff <= arg_sy_in;
      tmp_ff    <= tmp_in;
      raw_ff    <= raw_in;
      prod_ff   <= prod_in;
      out_px_ff <= out_px_in;
      out_py_ff <= out_py_in;
      out_vx_ff <= out_vx_in;
      out_vy_ff <= out_vy_in;
      out_hd_ff <= out_hd_in;
      out_sp_ff <= out_sp_in;
   end

   assign req_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_position_x = out_px_ff;
   assign rsp_position_y = out_py_ff;
   assign rsp_velocity_x = out_vx_ff;
   assign rsp_velocity_y = out_vy_ff;
   assign rsp_heading    = out_hd_ff;
   assign rsp_spin_rate  = out_sp_ff;

`ifndef SYNTHESIS
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("sequencer stayed idle after an input transfer");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result raised outside the completion state");

   a_tick_pc_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MUL || state_ff == S_ACC) && tick_ff) |-> (pc_ff <= TICK_LAST))
      else $error("tick program counter ran past its last step");

   a_force_pc_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_MUL || state_ff == S_ACC) && !tick_ff) |-> (pc_ff >= FORCE_BASE))
      else $error("force program counter left its program");

   a_vx_rest_snap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && tick_ff) |->
         (vel_x_ff == '0 || vel_x_ff >= LINEAR_REST_LIMIT || vel_x_ff <= -LINEAR_REST_LIMIT))
      else $error("velocity x below rest limit after tick");

   a_spin_rest_snap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && tick_ff) |->
         (spin_ff == '0 || spin_ff >= ANGULAR_REST_LIMIT || spin_ff <= -ANGULAR_REST_LIMIT))
      else $error("spin below rest limit after tick");
`endif

endmodule

// File: tb/rigid_body_2d_integrator_tb.sv
`timescale 1ns / 100ps

module rigid_body_2d_integrator_tb;
   import rb2d_pkg::*;

   localparam int LIMIT_CYCLES    = 400000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int DRAIN_CYCLES    = 40;
   localparam int HOLDOFF_CYCLES  = 300;

   localparam logic [1:0]        OP_UNUSED = 2'd3;   // no operation behind this code
   localparam logic signed [31:0] QMAX     = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] QMIN     = 32'sh8000_0000;
   localparam logic [31:0]       COEF_MAX  = 32'h7FFF_FFFF;
   localparam logic [31:0]       EARTH_G   = 32'hFFF6_3333;  // -9.8 in Q16.16

   typedef logic signed [DATA_W-1:0] q16_t;

   typedef struct packed {
      q16_t pos_x, pos_y, vel_x, vel_y, heading, spin;
   } body_state_t;

   typedef struct packed {
      logic [1:0] op;
      q16_t       first_x, first_y, second_x, second_y, set_heading, set_spin;
   } body_cmd_t;

   // One row of the directed table: either a register write or an item, and for
   // items whose result is obvious, the result typed in by hand.
   typedef struct {
      bit          is_csr;
      reg_type     csr_reg;
      logic [31:0] csr_value;
      body_cmd_t   cmd;
      bit          typed;
      body_state_t want;
   } stim_row_t;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [1:0]        req_operation = '0;
   q16_t              req_first_x = '0;
   q16_t              req_first_y = '0;
   q16_t              req_second_x = '0;
   q16_t              req_second_y = '0;
   q16_t              req_set_heading = '0;
   q16_t              req_set_spin = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   q16_t              rsp_position_x;
   q16_t              rsp_position_y;
   q16_t              rsp_velocity_x;
   q16_t              rsp_velocity_y;
   q16_t              rsp_heading;
   q16_t              rsp_spin_rate;
   logic              csr_psel = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite = 1'b0;
   logic [ADDR_W-1:0] csr_paddr = '0;
   logic [DATA_W-1:0] csr_pwdata = '0;
   logic [DATA_W-1:0] csr_prdata;
   logic              csr_pready;

   rigid_body_2d_integrator dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_first_x     (req_first_x),
      .req_first_y     (req_first_y),
      .req_second_x    (req_second_x),
      .req_second_y    (req_second_y),
      .req_set_heading (req_set_heading),
      .req_set_spin    (req_set_spin),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_position_x  (rsp_position_x),
      .rsp_position_y  (rsp_position_y),
      .rsp_velocity_x  (rsp_velocity_x),
      .rsp_velocity_y  (rsp_velocity_y),
      .rsp_heading     (rsp_heading),
      .rsp_spin_rate   (rsp_spin_rate),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predicted body: own copy of the state and of every register.
   // ------------------------------------------------------------------
   body_state_t body;
   q16_t        grav_x, grav_y;
   longint      step_len, lin_drag, ang_drag, inv_mass, inv_moment;
   bit          kinematic_mode;

   body_state_t expected_states[$];   // predicted results, oldest first
   stim_row_t   directed_rows[$];

   int fail_count    = 0;
   int results_seen  = 0;
   int csr_writes    = 0;
   int cycle_count   = 0;
   int op_seen[4]    = '{0, 0, 0, 0};
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int holdoff_request = 0;   // set by the stimulus, picked up by the receiver
   int holdoff_left    = 0;

   // Saturate a wide intermediate to 32-bit signed.
   function automatic q16_t clamp_q32(input longint v);
      if (v > longint'(QMAX)) return QMAX;
      if (v < longint'(QMIN)) return QMIN;
      return q16_t'(v[31:0]);
   endfunction

   // Q16.16 product, floored: arithmetic shift of the exact 64-bit product.
   function automatic longint fixed_prod(input longint a, input longint b);
      return (a * b) >>> FRAC_W;
   endfunction

   function automatic q16_t fixed_mul(input longint a, input longint b);
      return clamp_q32(fixed_prod(a, b));
   endfunction

   function automatic q16_t sat_add(input q16_t a, input q16_t b);
      return clamp_q32(longint'(a) + longint'(b));
   endfunction

   function automatic q16_t sat_sub(input q16_t a, input q16_t b);
      return clamp_q32(longint'(a) - longint'(b));
   endfunction

   // Drag: subtract (v * coef) * step, each product floored and saturated.
   function automatic q16_t damp(input q16_t v, input longint coef);
      return sat_sub(v, fixed_mul(fixed_mul(v, coef), step_len));
   endfunction

   function automatic bit at_rest(input q16_t v, input q16_t limit);
      return (v < 0 ? -longint'(v) : longint'(v)) < longint'(limit);
   endfunction

   // Advance the predicted body by one accepted item and return the new state.
   function automatic body_state_t integrate_item(input body_cmd_t c);
      q16_t torque;
      case (c.op)
         OP_TICK: begin
            if (kinematic_mode) begin
               // kinematic body: drop all motion, keep pose
               body.vel_x = '0;
               body.vel_y = '0;
               body.spin  = '0;
            end else begin
               // position moves by the old velocity
               body.pos_x   = sat_add(body.pos_x, fixed_mul(body.vel_x, step_len));
               body.pos_y   = sat_add(body.pos_y, fixed_mul(body.vel_y, step_len));
               body.vel_x   = sat_add(body.vel_x, fixed_mul(grav_x, step_len));
               body.vel_y   = sat_add(body.vel_y, fixed_mul(grav_y, step_len));
               body.vel_x   = damp(body.vel_x, lin_drag);
               body.vel_y   = damp(body.vel_y, lin_drag);
               body.spin    = damp(body.spin, ang_drag);
               // heading moves by the new spin
               body.heading = sat_add(body.heading, fixed_mul(body.spin, step_len));
               // snap slow x motion and slow spin to rest; y is never snapped
               if (at_rest(body.vel_x, LINEAR_REST_LIMIT)) body.vel_x = '0;
               if (at_rest(body.spin, ANGULAR_REST_LIMIT)) body.spin = '0;
            end
         end
         OP_FORCE: begin
            torque = clamp_q32(fixed_prod(c.first_y, c.second_x)
                               - fixed_prod(c.first_x, c.second_y));
            body.vel_x = sat_add(body.vel_x, fixed_mul(c.first_x, inv_mass));
            body.vel_y = sat_add(body.vel_y, fixed_mul(c.first_y, inv_mass));
            body.spin  = sat_add(body.spin, fixed_mul(torque, inv_moment));
         end
         OP_SET: begin
            body = '{c.first_x, c.first_y, c.second_x, c.second_y,
                     c.set_heading, c.set_spin};
         end
         default: ;   // unused code: state holds, result repeats it
      endcase
      return body;
   endfunction

   // Mirror a register write into the predictor; coefficients keep 31 bits.
   function automatic void set_model_reg(input reg_type r, input logic [31:0] v);
      case (r)
         REG_GRAVITY_X:      grav_x = q16_t'(v);
         REG_GRAVITY_Y:      grav_y = q16_t'(v);
         REG_TIME_STEP:      step_len = longint'({33'd0, v[30:0]});
         REG_LINEAR_DRAG:    lin_drag = longint'({33'd0, v[30:0]});
         REG_ANGULAR_DRAG:   ang_drag = longint'({33'd0, v[30:0]});
         REG_INVERSE_MASS:   inv_mass = longint'({33'd0, v[30:0]});
         REG_INVERSE_MOMENT: inv_moment = longint'({33'd0, v[30:0]});
         REG_KINEMATIC:      kinematic_mode = v[0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Stimulus values
   // ------------------------------------------------------------------
   // Mostly moderate magnitudes, with full-range words and extremes mixed in.
   function automatic q16_t rand_q16();
      logic [31:0] magnitude;
      case ($urandom_range(0, 9))
         0: case ($urandom_range(0, 4))
               0: return QMAX;
               1: return QMIN;
               2: return '0;
               3: return -1;
               default: return 1;
            endcase
         1, 2: return $urandom;
         default: begin
            magnitude = $urandom_range(0, 32'h40_0000);
            return $urandom_range(0, 1) ? -q16_t'(magnitude) : q16_t'(magnitude);
         end
      endcase
   endfunction

   function automatic logic [31:0] rand_coef();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return COEF_MAX;
         2: return 32'd65536;
         3: return $urandom_range(0, 4096);
         4: return $urandom_range(0, 131072);
         default: return $urandom & COEF_MAX;
      endcase
   endfunction

   // Ticks dominate so the state evolves; loads pull it back from saturation.
   function automatic body_cmd_t random_cmd();
      body_cmd_t c;
      int        roll;
      roll = $urandom_range(0, 99);
      if (roll < 45)      c.op = OP_TICK;
      else if (roll < 75) c.op = OP_FORCE;
      else if (roll < 96) c.op = OP_SET;
      else                c.op = OP_UNUSED;
      c.first_x     = rand_q16();
      c.first_y     = rand_q16();
      c.second_x    = rand_q16();
      c.second_y    = rand_q16();
      c.set_heading = rand_q16();
      c.set_spin    = rand_q16();
      return c;
   endfunction

   function automatic stim_row_t item_row(input logic [1:0] op,
                                          input q16_t fx, fy, sx, sy, hd, sp);
      stim_row_t r;
      r.is_csr    = 1'b0;
      r.csr_reg   = REG_GRAVITY_X;
      r.csr_value = '0;
      r.cmd       = '{op, fx, fy, sx, sy, hd, sp};
      r.typed     = 1'b0;
      r.want      = '0;
      return r;
   endfunction

   function automatic stim_row_t typed_row(input stim_row_t r,
                                           input q16_t px, py, vx, vy, hd, sp);
      r.typed = 1'b1;
      r.want  = '{px, py, vx, vy, hd, sp};
      return r;
   endfunction

   function automatic stim_row_t csr_row(input reg_type g, input logic [31:0] v);
      stim_row_t r;
      r           = item_row(OP_TICK, 0, 0, 0, 0, 0, 0);
      r.is_csr    = 1'b1;
      r.csr_reg   = g;
      r.csr_value = v;
      return r;
   endfunction

   // Append a row at the end of the directed table.
   function automatic void add_row(input stim_row_t r);
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   // ------------------------------------------------------------------
   // Bus tasks
   // ------------------------------------------------------------------
   // Offer one item: idle at random first, then hold valid and payload until
   // the transfer, and record what the body must report for it.
   task automatic push_item(input body_cmd_t c, input bit typed, input body_state_t want);
      body_state_t predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_operation   <= c.op;
      req_first_x     <= c.first_x;
      req_first_y     <= c.first_y;
      req_second_x    <= c.second_x;
      req_second_y    <= c.second_y;
      req_set_heading <= c.set_heading;
      req_set_spin    <= c.set_spin;
      do @(posedge clock); while (!req_ready);
      predicted = integrate_item(c);
      expected_states.insert(expected_states.size(), typed ? want : predicted);
      op_seen[c.op]++;
   endtask

   // Drop valid and hold off until every outstanding result has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_states.size() != 0) @(posedge clock);
   endtask

   // Setup cycle, then access cycle; the register takes the value at the edge
   // where the access completes.
   task automatic csr_write(input reg_type r, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {r, 2'b00};
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      set_model_reg(r, v);
      csr_writes++;
      @(posedge clock);
   endtask

   // Each phase writes every register: nominal values with earth gravity,
   // all coefficients at their maximum, all at zero, then random settings
   // (one of them kinematic).
   task automatic write_phase_config(input int p);
      logic [31:0] vals[8];
      case (p)
         0: vals = '{32'd0, EARTH_G, 32'd1092, 32'd19661, 32'd19661,
                     32'd65536, 32'd65536, 32'd0};
         1: vals = '{QMAX, QMIN, COEF_MAX, COEF_MAX, COEF_MAX,
                     COEF_MAX, COEF_MAX, 32'd0};
         2: vals = '{QMIN, QMAX, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0};
         default: begin
            vals[REG_GRAVITY_X] = rand_q16();
            vals[REG_GRAVITY_Y] = rand_q16();
            for (int i = REG_TIME_STEP; i <= REG_INVERSE_MOMENT; i++) vals[i] = rand_coef();
            vals[REG_KINEMATIC] = (p == 6);
         end
      endcase
      for (int i = REG_GRAVITY_X; i <= REG_KINEMATIC; i++) csr_write(reg_type'(i), vals[i]);
   endtask

   function automatic void check_field(input string name, input q16_t want, input q16_t got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endfunction

   // ------------------------------------------------------------------
   // Result side: check each transfer against the oldest expectation, then
   // decide whether to stall next cycle. A hold-off request takes priority
   // over random stalls and is counted down here, cycle by cycle.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      body_state_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (expected_states.size() == 0) begin
            $error("rsp transfer with no result outstanding");
            fail_count++;
         end else begin
            want = expected_states.pop_front();
            check_field("position_x", want.pos_x, rsp_position_x);
            check_field("position_y", want.pos_y, rsp_position_y);
            check_field("velocity_x", want.vel_x, rsp_velocity_x);
            check_field("velocity_y", want.vel_y, rsp_velocity_y);
            check_field("heading", want.heading, rsp_heading);
            check_field("spin_rate", want.spin, rsp_spin_rate);
         end
      end
      if (holdoff_left > 0) begin
         holdoff_left--;
         rsp_ready <= 1'b0;
      end else if (holdoff_request > 0) begin
         holdoff_left    = holdoff_request - 1;
         holdoff_request = 0;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("rigid_body_2d_integrator test failed");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus sequence
   // ------------------------------------------------------------------
   initial begin
      // predictor starts from the reset state of the block
      body           = '0;
      grav_x         = '0;
      grav_y         = '0;
      step_len       = 1092;
      lin_drag       = 19661;
      ang_drag       = 19661;
      inv_mass       = 65536;
      inv_moment     = 65536;
      kinematic_mode = 1'b0;

      reset <= 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed table, starting from the reset register values.
      // tick out of reset: nothing moves
      add_row(typed_row(item_row(OP_TICK, 0, 0, 0, 0, 0, 0),
                        0, 0, 0, 0, 0, 0));
      // load the state at the field extremes, both ways round
      add_row(typed_row(item_row(OP_SET, QMAX, QMIN, QMAX, QMIN, QMAX, QMIN),
                        QMAX, QMIN, QMAX, QMIN, QMAX, QMIN));
      // unused code leaves the state alone
      add_row(typed_row(item_row(OP_UNUSED, QMIN, QMAX, 1, -1, QMIN, QMAX),
                        QMAX, QMIN, QMAX, QMIN, QMAX, QMIN));
      add_row(item_row(OP_TICK, 0, 0, 0, 0, 0, 0));
      add_row(typed_row(item_row(OP_SET, QMIN, QMAX, QMIN, QMAX, QMIN, QMAX),
                        QMIN, QMAX, QMIN, QMAX, QMIN, QMAX));
      add_row(item_row(OP_TICK, QMAX, QMAX, QMAX, QMAX, QMAX, QMAX));
      // forces that drive the torque into negative saturation, two ways
      add_row(item_row(OP_FORCE, QMAX, QMIN, QMAX, QMAX, 0, 0));
      add_row(item_row(OP_FORCE, QMIN, QMAX, QMIN, QMIN, -1, -1));
      add_row(typed_row(item_row(OP_SET, 0, 0, 0, 0, 0, 0),
                        0, 0, 0, 0, 0, 0));
      add_row(item_row(OP_FORCE, 65536, -65536, 0, 65536, 0, 0));
      add_row(item_row(OP_TICK, 0, 0, 0, 0, 0, 0));
      // zero step: a tick only applies the rest snap; probe both sides of the limits
      add_row(csr_row(REG_TIME_STEP, 32'd0));
      add_row(typed_row(item_row(OP_SET, 100, -100, 13107, -3, 1, 655),
                        100, -100, 13107, -3, 1, 655));
      add_row(typed_row(item_row(OP_TICK, 0, 0, 0, 0, 0, 0),
                        100, -100, 13107, -3, 1, 655));
      add_row(typed_row(item_row(OP_SET, 0, 0, -13106, 7, -1, -654),
                        0, 0, -13106, 7, -1, -654));
      add_row(typed_row(item_row(OP_TICK, 0, 0, 0, 0, 0, 0),
                        0, 0, 0, 7, -1, 0));
      // kinematic: tick kills motion, force still acts
      add_row(csr_row(REG_KINEMATIC, 32'd1));
      add_row(typed_row(item_row(OP_SET, 5, 6, QMAX, QMIN, 8, QMAX),
                        5, 6, QMAX, QMIN, 8, QMAX));
      add_row(typed_row(item_row(OP_TICK, 0, 0, 0, 0, 0, 0),
                        5, 6, 0, 0, 8, 0));
      add_row(item_row(OP_FORCE, 65536, 65536, 65536, 0, 0, 0));
      add_row(csr_row(REG_KINEMATIC, 32'd0));
      add_row(csr_row(REG_TIME_STEP, COEF_MAX));
      add_row(item_row(OP_TICK, 0, 0, 0, 0, 0, 0));

      foreach (directed_rows[i]) begin
         if (directed_rows[i].is_csr) begin
            wait_for_results();
            csr_write(directed_rows[i].csr_reg, directed_rows[i].csr_value);
         end else begin
            push_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
         end
      end

      // Random phases: new register settings each time, cycling the idle mix
      // through none, sender idle, receiver stalls and light idling on both.
      for (int p = 0; p < PHASES; p++) begin
         wait_for_results();
         write_phase_config(p);
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 64; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 64; end
            default: begin send_idle_pct = 9; stall_pct = 9; end
         endcase
         // hold the result side off while items keep coming, to back up the input
         if (p == 4) holdoff_request = HOLDOFF_CYCLES;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // halfway through, pause the sender until the body is empty
            if (n == ITEMS_PER_PHASE / 2) wait_for_results();
            push_item(random_cmd(), 1'b0, '0);
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d ticks, %0d forces, %0d state loads and %0d unused-code items",
               op_seen[OP_TICK], op_seen[OP_FORCE], op_seen[OP_SET], op_seen[OP_UNUSED]);
      $display("over %0d register writes; %0d results checked, with a %0d-cycle hold-off.",
               csr_writes, results_seen, HOLDOFF_CYCLES);
      if (fail_count == 0) begin
         $display("rigid_body_2d_integrator test passed");
      end else begin
         $display("rigid_body_2d_integrator test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/rb2d_pkg.sv
rtl/core/rigid_body_2d_integrator.sv
tb/rigid_body_2d_integrator_tb.sv
